/* rtl/core/obbsat_pkg.sv */
// obbsat_pkg: width helpers shared by the oriented box overlap pipeline
// no dependencies; imported by every module of the block

package obbsat_pkg;

  // word size at which the arithmetic of the box test wraps
  localparam int WORD_W = 64;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int imin(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  // center offset, one bit over the coordinate
  function automatic int ofs_w(input int cw);
    return cw + 1;
  endfunction

  // offset times a trig value
  function automatic int prod_w(input int cw, input int tw);
    return cw + 1 + tw;
  endfunction

  // magnitude of a relative rotation entry
  function automatic int mag_w(input int tw);
    return 2 * tw;
  endfunction

  // projection of the offset on a box axis
  function automatic int proj_w(input int cw, input int tw);
    return cw + tw + 2;
  endfunction

  // widened extent, sum of two magnitude times half size products
  function automatic int ext_w(input int cw, input int tw);
    return 2 * tw + cw;
  endfunction

endpackage

/* rtl/core/obbsat_front.sv */
// obbsat_front: stages one and two, center offsets, relative rotation and
// projection products; depends on obbsat_pkg

module obbsat_front
  import obbsat_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int TRIG_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic signed [COORD_WIDTH-1:0] a_center_x,
  input  logic signed [COORD_WIDTH-1:0] a_center_y,
  input  logic        [COORD_WIDTH-2:0] a_half_w,
  input  logic        [COORD_WIDTH-2:0] a_half_h,
  input  logic signed [TRIG_WIDTH-1:0]  a_cos,
  input  logic signed [TRIG_WIDTH-1:0]  a_sin,
  input  logic signed [COORD_WIDTH-1:0] b_center_x,
  input  logic signed [COORD_WIDTH-1:0] b_center_y,
  input  logic        [COORD_WIDTH-2:0] b_half_w,
  input  logic        [COORD_WIDTH-2:0] b_half_h,
  input  logic signed [TRIG_WIDTH-1:0]  b_cos,
  input  logic signed [TRIG_WIDTH-1:0]  b_sin,
  output logic                          vld,
  output logic [mag_w(TRIG_WIDTH)-1:0]  p_mag,
  output logic [mag_w(TRIG_WIDTH)-1:0]  q_mag,
  output logic signed [prod_w(COORD_WIDTH, TRIG_WIDTH)-1:0] bc_dx,
  output logic signed [prod_w(COORD_WIDTH, TRIG_WIDTH)-1:0] bs_dy,
  output logic signed [prod_w(COORD_WIDTH, TRIG_WIDTH)-1:0] bs_dx,
  output logic signed [prod_w(COORD_WIDTH, TRIG_WIDTH)-1:0] bc_dy,
  output logic signed [prod_w(COORD_WIDTH, TRIG_WIDTH)-1:0] ac_dx,
  output logic signed [prod_w(COORD_WIDTH, TRIG_WIDTH)-1:0] as_dy,
  output logic signed [prod_w(COORD_WIDTH, TRIG_WIDTH)-1:0] as_dx,
  output logic signed [prod_w(COORD_WIDTH, TRIG_WIDTH)-1:0] ac_dy,
  output logic        [COORD_WIDTH-2:0] a_half_w_o,
  output logic        [COORD_WIDTH-2:0] a_half_h_o,
  output logic        [COORD_WIDTH-2:0] b_half_w_o,
  output logic        [COORD_WIDTH-2:0] b_half_h_o
);

  localparam int D_W   = ofs_w(COORD_WIDTH);
  localparam int TP_W  = 2 * TRIG_WIDTH;
  localparam int M_W   = 2 * TRIG_WIDTH + 1;
  localparam int MAG_W = mag_w(TRIG_WIDTH);
  localparam int PP_W  = prod_w(COORD_WIDTH, TRIG_WIDTH);

  // stage one registers
  logic                    s1_vld_r;
  logic signed [D_W-1:0]   dx_r, dy_r;
  logic signed [D_W-1:0]   dx_nxt, dy_nxt;
  logic signed [TP_W-1:0]  cc_r, ss_r, sc_r, cs_r;
  logic signed [TP_W-1:0]  cc_nxt, ss_nxt, sc_nxt, cs_nxt;
  logic signed [TRIG_WIDTH-1:0]  a_cos_r, a_sin_r, b_cos_r, b_sin_r;
  logic [COORD_WIDTH-2:0]  s1_ahw_r, s1_ahh_r, s1_bhw_r, s1_bhh_r;

  // stage two registers
  logic                    s2_vld_r;
  logic [MAG_W-1:0]        p_mag_r, q_mag_r, p_mag_nxt, q_mag_nxt;
  logic signed [M_W-1:0]   m_diag, m_cross;
  logic [M_W-1:0]          m_diag_abs, m_cross_abs;
  logic signed [PP_W-1:0]  bc_dx_r, bs_dy_r, bs_dx_r, bc_dy_r;
  logic signed [PP_W-1:0]  ac_dx_r, as_dy_r, as_dx_r, ac_dy_r;
  logic signed [PP_W-1:0]  bc_dx_nxt, bs_dy_nxt, bs_dx_nxt, bc_dy_nxt;
  logic signed [PP_W-1:0]  ac_dx_nxt, as_dy_nxt, as_dx_nxt, ac_dy_nxt;
  logic [COORD_WIDTH-2:0]  s2_ahw_r, s2_ahh_r, s2_bhw_r, s2_bhh_r;

  // offsets of the first center from the second, and trig cross products
  always_comb begin
    dx_nxt = D_W'(a_center_x) - D_W'(b_center_x);
    dy_nxt = D_W'(a_center_y) - D_W'(b_center_y);
    cc_nxt = a_cos * b_cos;
    ss_nxt = a_sin * b_sin;
    sc_nxt = a_sin * b_cos;
    cs_nxt = a_cos * b_sin;
  end

  // relative rotation magnitudes; all four entries reduce to two values
  always_comb begin
    m_diag      = M_W'(cc_r) + M_W'(ss_r);
    m_cross     = M_W'(sc_r) - M_W'(cs_r);
    m_diag_abs  = m_diag[M_W-1] ? (~m_diag + M_W'(1)) : m_diag;
    m_cross_abs = m_cross[M_W-1] ? (~m_cross + M_W'(1)) : m_cross;
    p_mag_nxt   = m_diag_abs[MAG_W-1:0];
    q_mag_nxt   = m_cross_abs[MAG_W-1:0];
  end

  // offset times trig for both reference frames
  always_comb begin
    bc_dx_nxt = b_cos_r * dx_r;
    bs_dy_nxt = b_sin_r * dy_r;
    bs_dx_nxt = b_sin_r * dx_r;
    bc_dy_nxt = b_cos_r * dy_r;
    ac_dx_nxt = a_cos_r * dx_r;
    as_dy_nxt = a_sin_r * dy_r;
    as_dx_nxt = a_sin_r * dx_r;
    ac_dy_nxt = a_cos_r * dy_r;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    cc_r     <= cc_nxt;
    ss_r     <= ss_nxt;
    sc_r     <= sc_nxt;
    cs_r     <= cs_nxt;
    a_cos_r  <= a_cos;
    a_sin_r  <= a_sin;
    b_cos_r  <= b_cos;
    b_sin_r  <= b_sin;
    s1_ahw_r <= a_half_w;
    s1_ahh_r <= a_half_h;
    s1_bhw_r <= b_half_w;
    s1_bhh_r <= b_half_h;
    p_mag_r  <= p_mag_nxt;
    q_mag_r  <= q_mag_nxt;
    bc_dx_r  <= bc_dx_nxt;
    bs_dy_r  <= bs_dy_nxt;
    bs_dx_r  <= bs_dx_nxt;
    bc_dy_r  <= bc_dy_nxt;
    ac_dx_r  <= ac_dx_nxt;
    as_dy_r  <= as_dy_nxt;
    as_dx_r  <= as_dx_nxt;
    ac_dy_r  <= ac_dy_nxt;
    s2_ahw_r <= s1_ahw_r;
    s2_ahh_r <= s1_ahh_r;
    s2_bhw_r <= s1_bhw_r;
    s2_bhh_r <= s1_bhh_r;
  end

  assign vld        = s2_vld_r;
  assign p_mag      = p_mag_r;
  assign q_mag      = q_mag_r;
  assign bc_dx      = bc_dx_r;
  assign bs_dy      = bs_dy_r;
  assign bs_dx      = bs_dx_r;
  assign bc_dy      = bc_dy_r;
  assign ac_dx      = ac_dx_r;
  assign as_dy      = as_dy_r;
  assign as_dx      = as_dx_r;
  assign ac_dy      = ac_dy_r;
  assign a_half_w_o = s2_ahw_r;
  assign a_half_h_o = s2_ahh_r;
  assign b_half_w_o = s2_bhw_r;
  assign b_half_h_o = s2_bhh_r;

endmodule

/* rtl/core/obbsat_span.sv */
// obbsat_span: stages three and four, axis projections and widened extents
// depends on obbsat_pkg

module obbsat_span
  import obbsat_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int TRIG_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [mag_w(TRIG_WIDTH)-1:0]  p_mag,
  input  logic [mag_w(TRIG_WIDTH)-1:0]  q_mag,
  input  logic signed [prod_w(COORD_WIDTH, TRIG_WIDTH)-1:0] bc_dx,
  input  logic signed [prod_w(COORD_WIDTH, TRIG_WIDTH)-1:0] bs_dy,
  input  logic signed [prod_w(COORD_WIDTH, TRIG_WIDTH)-1:0] bs_dx,
  input  logic signed [prod_w(COORD_WIDTH, TRIG_WIDTH)-1:0] bc_dy,
  input  logic signed [prod_w(COORD_WIDTH, TRIG_WIDTH)-1:0] ac_dx,
  input  logic signed [prod_w(COORD_WIDTH, TRIG_WIDTH)-1:0] as_dy,
  input  logic signed [prod_w(COORD_WIDTH, TRIG_WIDTH)-1:0] as_dx,
  input  logic signed [prod_w(COORD_WIDTH, TRIG_WIDTH)-1:0] ac_dy,
  input  logic        [COORD_WIDTH-2:0] a_half_w,
  input  logic        [COORD_WIDTH-2:0] a_half_h,
  input  logic        [COORD_WIDTH-2:0] b_half_w,
  input  logic        [COORD_WIDTH-2:0] b_half_h,
  output logic                          vld,
  output logic signed [proj_w(COORD_WIDTH, TRIG_WIDTH)-1:0] proj_b0,
  output logic signed [proj_w(COORD_WIDTH, TRIG_WIDTH)-1:0] proj_b1,
  output logic signed [proj_w(COORD_WIDTH, TRIG_WIDTH)-1:0] proj_a0,
  output logic signed [proj_w(COORD_WIDTH, TRIG_WIDTH)-1:0] proj_a1,
  output logic [ext_w(COORD_WIDTH, TRIG_WIDTH)-1:0] ext_b0,
  output logic [ext_w(COORD_WIDTH, TRIG_WIDTH)-1:0] ext_b1,
  output logic [ext_w(COORD_WIDTH, TRIG_WIDTH)-1:0] ext_a0,
  output logic [ext_w(COORD_WIDTH, TRIG_WIDTH)-1:0] ext_a1,
  output logic        [COORD_WIDTH-2:0] a_half_w_o,
  output logic        [COORD_WIDTH-2:0] a_half_h_o,
  output logic        [COORD_WIDTH-2:0] b_half_w_o,
  output logic        [COORD_WIDTH-2:0] b_half_h_o
);

  localparam int PJ_W = proj_w(COORD_WIDTH, TRIG_WIDTH);
  localparam int EX_W = ext_w(COORD_WIDTH, TRIG_WIDTH);
  localparam int EP_W = mag_w(TRIG_WIDTH) + COORD_WIDTH - 1;

  // stage three registers
  logic                   s3_vld_r;
  logic signed [PJ_W-1:0] pb0_r, pb1_r, pa0_r, pa1_r;
  logic signed [PJ_W-1:0] pb0_nxt, pb1_nxt, pa0_nxt, pa1_nxt;
  logic [EP_W-1:0]        p_ahw_r, q_ahh_r, q_ahw_r, p_ahh_r;
  logic [EP_W-1:0]        p_bhw_r, q_bhh_r, q_bhw_r, p_bhh_r;
  logic [EP_W-1:0]        p_ahw_nxt, q_ahh_nxt, q_ahw_nxt, p_ahh_nxt;
  logic [EP_W-1:0]        p_bhw_nxt, q_bhh_nxt, q_bhw_nxt, p_bhh_nxt;
  logic [COORD_WIDTH-2:0] s3_ahw_r, s3_ahh_r, s3_bhw_r, s3_bhh_r;

  // stage four registers
  logic                   s4_vld_r;
  logic signed [PJ_W-1:0] s4_pb0_r, s4_pb1_r, s4_pa0_r, s4_pa1_r;
  logic [EX_W-1:0]        eb0_r, eb1_r, ea0_r, ea1_r;
  logic [EX_W-1:0]        eb0_nxt, eb1_nxt, ea0_nxt, ea1_nxt;
  logic [COORD_WIDTH-2:0] s4_ahw_r, s4_ahh_r, s4_bhw_r, s4_bhh_r;

  // projections; the first frame sees the negated offset
  always_comb begin
    pb0_nxt = PJ_W'(bc_dx) + PJ_W'(bs_dy);
    pb1_nxt = PJ_W'(bc_dy) - PJ_W'(bs_dx);
    pa0_nxt = -PJ_W'(ac_dx) - PJ_W'(as_dy);
    pa1_nxt = PJ_W'(as_dx) - PJ_W'(ac_dy);
  end

  // rotation magnitudes times the other box half sizes
  always_comb begin
    p_ahw_nxt = p_mag * a_half_w;
    q_ahh_nxt = q_mag * a_half_h;
    q_ahw_nxt = q_mag * a_half_w;
    p_ahh_nxt = p_mag * a_half_h;
    p_bhw_nxt = p_mag * b_half_w;
    q_bhh_nxt = q_mag * b_half_h;
    q_bhw_nxt = q_mag * b_half_w;
    p_bhh_nxt = p_mag * b_half_h;
  end

  // extents per axis
  always_comb begin
    eb0_nxt = EX_W'(p_ahw_r) + EX_W'(q_ahh_r);
    eb1_nxt = EX_W'(q_ahw_r) + EX_W'(p_ahh_r);
    ea0_nxt = EX_W'(p_bhw_r) + EX_W'(q_bhh_r);
    ea1_nxt = EX_W'(q_bhw_r) + EX_W'(p_bhh_r);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= in_vld;
      s4_vld_r <= s3_vld_r;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    pb0_r    <= pb0_nxt;
    pb1_r    <= pb1_nxt;
    pa0_r    <= pa0_nxt;
    pa1_r    <= pa1_nxt;
    p_ahw_r  <= p_ahw_nxt;
    q_ahh_r  <= q_ahh_nxt;
    q_ahw_r  <= q_ahw_nxt;
    p_ahh_r  <= p_ahh_nxt;
    p_bhw_r  <= p_bhw_nxt;
    q_bhh_r  <= q_bhh_nxt;
    q_bhw_r  <= q_bhw_nxt;
    p_bhh_r  <= p_bhh_nxt;
    s3_ahw_r <= a_half_w;
    s3_ahh_r <= a_half_h;
    s3_bhw_r <= b_half_w;
    s3_bhh_r <= b_half_h;
    s4_pb0_r <= pb0_r;
    s4_pb1_r <= pb1_r;
    s4_pa0_r <= pa0_r;
    s4_pa1_r <= pa1_r;
    eb0_r    <= eb0_nxt;
    eb1_r    <= eb1_nxt;
    ea0_r    <= ea0_nxt;
    ea1_r    <= ea1_nxt;
    s4_ahw_r <= s3_ahw_r;
    s4_ahh_r <= s3_ahh_r;
    s4_bhw_r <= s3_bhw_r;
    s4_bhh_r <= s3_bhh_r;
  end

  assign vld        = s4_vld_r;
  assign proj_b0    = s4_pb0_r;
  assign proj_b1    = s4_pb1_r;
  assign proj_a0    = s4_pa0_r;
  assign proj_a1    = s4_pa1_r;
  assign ext_b0     = eb0_r;
  assign ext_b1     = eb1_r;
  assign ext_a0     = ea0_r;
  assign ext_a1     = ea1_r;
  assign a_half_w_o = s4_ahw_r;
  assign a_half_h_o = s4_ahh_r;
  assign b_half_w_o = s4_bhw_r;
  assign b_half_h_o = s4_bhh_r;

endmodule

/* rtl/core/obbsat_axis_cmp.sv */
// obbsat_axis_cmp: stage five, separation test on one box axis
// depends on obbsat_pkg

module obbsat_axis_cmp
  import obbsat_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int TRIG_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic signed [proj_w(COORD_WIDTH, TRIG_WIDTH)-1:0] proj,
  input  logic [ext_w(COORD_WIDTH, TRIG_WIDTH)-1:0] ext,
  input  logic        [COORD_WIDTH-2:0] half,
  output logic                          sep
);

  localparam int FRAC  = TRIG_WIDTH - 1;
  localparam int PJ_W  = proj_w(COORD_WIDTH, TRIG_WIDTH);
  localparam int EX_W  = ext_w(COORD_WIDTH, TRIG_WIDTH);
  localparam int E_W   = imax(imax(PJ_W + FRAC, EX_W + 1), COORD_WIDTH + 2 * FRAC) + 1;
  localparam int CMP_W = imin(E_W, WORD_W);

  logic signed [E_W-1:0]   c_full, e_full, h_full;
  logic signed [E_W-1:0]   hi_full, lo_full, nh_full;
  logic signed [CMP_W-1:0] hi_t, lo_t, nh_t, h_t;
  logic                    sep_r, sep_nxt;

  // exact interval of the other box on this axis, wrapped to the word size
  always_comb begin
    c_full  = E_W'(proj) <<< FRAC;
    e_full  = E_W'(ext);
    h_full  = E_W'(half) <<< (2 * FRAC);
    hi_full = c_full + e_full;
    lo_full = c_full - e_full;
    nh_full = -h_full;
    hi_t    = hi_full[CMP_W-1:0];
    lo_t    = lo_full[CMP_W-1:0];
    nh_t    = nh_full[CMP_W-1:0];
    h_t     = h_full[CMP_W-1:0];
    // strict compares: touching boxes stay overlapping
    sep_nxt = (hi_t < nh_t) || (h_t < lo_t);
  end

  always_ff @(posedge clk) begin
    sep_r <= sep_nxt;
  end

  assign sep = sep_r;

endmodule

/* rtl/core/oriented_box_overlap_test_2d_unit.sv */
// oriented_box_overlap_test_2d_unit: separating axis overlap test of two 2D boxes
// the word passes the front stages, the span stages and the axis compare registers to the strobe
// throughput: one word per cycle; busy stays low, five register stages
// reset clears only the stage valid bits; no result strobe follows reset
// depends on obbsat_pkg, obbsat_front, obbsat_span, obbsat_axis_cmp

module oriented_box_overlap_test_2d_unit
  import obbsat_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int TRIG_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_a_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_center_y,
  input  logic        [COORD_WIDTH-2:0] in_a_half_w,
  input  logic        [COORD_WIDTH-2:0] in_a_half_h,
  input  logic signed [TRIG_WIDTH-1:0]  in_a_cos,
  input  logic signed [TRIG_WIDTH-1:0]  in_a_sin,
  input  logic signed [COORD_WIDTH-1:0] in_b_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_center_y,
  input  logic        [COORD_WIDTH-2:0] in_b_half_w,
  input  logic        [COORD_WIDTH-2:0] in_b_half_h,
  input  logic signed [TRIG_WIDTH-1:0]  in_b_cos,
  input  logic signed [TRIG_WIDTH-1:0]  in_b_sin,
  output logic                          out_valid,
  output logic                          out_overlap
);

  localparam int MAG_W = mag_w(TRIG_WIDTH);
  localparam int PP_W  = prod_w(COORD_WIDTH, TRIG_WIDTH);
  localparam int PJ_W  = proj_w(COORD_WIDTH, TRIG_WIDTH);
  localparam int EX_W  = ext_w(COORD_WIDTH, TRIG_WIDTH);

  logic                   in_vld;
  logic                   f_vld, s_vld;
  logic [MAG_W-1:0]       p_mag, q_mag;
  logic signed [PP_W-1:0] bc_dx, bs_dy, bs_dx, bc_dy;
  logic signed [PP_W-1:0] ac_dx, as_dy, as_dx, ac_dy;
  logic [COORD_WIDTH-2:0] f_ahw, f_ahh, f_bhw, f_bhh;
  logic [COORD_WIDTH-2:0] s_ahw, s_ahh, s_bhw, s_bhh;
  logic signed [PJ_W-1:0] proj_b0, proj_b1, proj_a0, proj_a1;
  logic [EX_W-1:0]        ext_b0, ext_b1, ext_a0, ext_a1;
  logic [3:0]             sep;
  logic                   out_valid_r;

  // the pipeline never stalls, so every start is taken
  assign busy   = 1'b0;
  assign in_vld = start && !busy;

  obbsat_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .TRIG_WIDTH  (TRIG_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (in_vld),
    .a_center_x (in_a_center_x),
    .a_center_y (in_a_center_y),
    .a_half_w   (in_a_half_w),
    .a_half_h   (in_a_half_h),
    .a_cos      (in_a_cos),
    .a_sin      (in_a_sin),
    .b_center_x (in_b_center_x),
    .b_center_y (in_b_center_y),
    .b_half_w   (in_b_half_w),
    .b_half_h   (in_b_half_h),
    .b_cos      (in_b_cos),
    .b_sin      (in_b_sin),
    .vld        (f_vld),
    .p_mag      (p_mag),
    .q_mag      (q_mag),
    .bc_dx      (bc_dx),
    .bs_dy      (bs_dy),
    .bs_dx      (bs_dx),
    .bc_dy      (bc_dy),
    .ac_dx      (ac_dx),
    .as_dy      (as_dy),
    .as_dx      (as_dx),
    .ac_dy      (ac_dy),
    .a_half_w_o (f_ahw),
    .a_half_h_o (f_ahh),
    .b_half_w_o (f_bhw),
    .b_half_h_o (f_bhh)
  );

  obbsat_span #(
    .COORD_WIDTH (COORD_WIDTH),
    .TRIG_WIDTH  (TRIG_WIDTH)
  ) u_span (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (f_vld),
    .p_mag      (p_mag),
    .q_mag      (q_mag),
    .bc_dx      (bc_dx),
    .bs_dy      (bs_dy),
    .bs_dx      (bs_dx),
    .bc_dy      (bc_dy),
    .ac_dx      (ac_dx),
    .as_dy      (as_dy),
    .as_dx      (as_dx),
    .ac_dy      (ac_dy),
    .a_half_w   (f_ahw),
    .a_half_h   (f_ahh),
    .b_half_w   (f_bhw),
    .b_half_h   (f_bhh),
    .vld        (s_vld),
    .proj_b0    (proj_b0),
    .proj_b1    (proj_b1),
    .proj_a0    (proj_a0),
    .proj_a1    (proj_a1),
    .ext_b0     (ext_b0),
    .ext_b1     (ext_b1),
    .ext_a0     (ext_a0),
    .ext_a1     (ext_a1),
    .a_half_w_o (s_ahw),
    .a_half_h_o (s_ahh),
    .b_half_w_o (s_bhw),
    .b_half_h_o (s_bhh)
  );

  // second box x and y axes, then first box x and y axes
  obbsat_axis_cmp #(
    .COORD_WIDTH (COORD_WIDTH),
    .TRIG_WIDTH  (TRIG_WIDTH)
  ) u_cmp_b0 (
    .clk  (clk),
    .proj (proj_b0),
    .ext  (ext_b0),
    .half (s_bhw),
    .sep  (sep[0])
  );

  obbsat_axis_cmp #(
    .COORD_WIDTH (COORD_WIDTH),
    .TRIG_WIDTH  (TRIG_WIDTH)
  ) u_cmp_b1 (
    .clk  (clk),
    .proj (proj_b1),
    .ext  (ext_b1),
    .half (s_bhh),
    .sep  (sep[1])
  );

  obbsat_axis_cmp #(
    .COORD_WIDTH (COORD_WIDTH),
    .TRIG_WIDTH  (TRIG_WIDTH)
  ) u_cmp_a0 (
    .clk  (clk),
    .proj (proj_a0),
    .ext  (ext_a0),
    .half (s_ahw),
    .sep  (sep[2])
  );

  obbsat_axis_cmp #(
    .COORD_WIDTH (COORD_WIDTH),
    .TRIG_WIDTH  (TRIG_WIDTH)
  ) u_cmp_a1 (
    .clk  (clk),
    .proj (proj_a1),
    .ext  (ext_a1),
    .half (s_ahh),
    .sep  (sep[3])
  );

  // result strobe, in step with the axis compare registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s_vld;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_overlap = ~(|sep);

endmodule

/* tb/sv/oriented_box_overlap_test_2d_unit_test.sv */
// testbench of oriented_box_overlap_test_2d_unit: two oriented boxes per word, one overlap flag
// self-checking: separating axis predictor, directed corner cases, random pairs under idling
// depends on rtl oriented_box_overlap_test_2d_unit and the modules below it
`timescale 1ns / 100ps

module oriented_box_overlap_test_2d_unit_test;

  localparam int CW          = 24;
  localparam int TW          = 16;
  localparam int TRIG_FRAC   = TW - 1;
  localparam int UNIT_POS    = 32767;
  localparam int UNIT_NEG    = -32768;
  localparam int CRD_MAX     = 8388607;
  localparam int CRD_MIN     = -8388608;
  localparam int HALF_MAX    = 8388607;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYC  = 12;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    logic signed [CW-1:0] a_cx, a_cy;
    logic        [CW-2:0] a_hw, a_hh;
    logic signed [TW-1:0] a_cos, a_sin;
    logic signed [CW-1:0] b_cx, b_cy;
    logic        [CW-2:0] b_hw, b_hh;
    logic signed [TW-1:0] b_cos, b_sin;
  } box_pair_t;

  typedef struct {
    int idx;
    bit overlap;
  } overlap_expect_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] in_a_center_x = '0, in_a_center_y = '0;
  logic        [CW-2:0] in_a_half_w = '0, in_a_half_h = '0;
  logic signed [TW-1:0] in_a_cos = '0, in_a_sin = '0;
  logic signed [CW-1:0] in_b_center_x = '0, in_b_center_y = '0;
  logic        [CW-2:0] in_b_half_w = '0, in_b_half_h = '0;
  logic signed [TW-1:0] in_b_cos = '0, in_b_sin = '0;
  logic out_valid;
  logic out_overlap;

  box_pair_t       pair_backlog_q[$];
  overlap_expect_t overlap_expect_q[$];
  box_pair_t       pair_on_port;
  overlap_expect_t head;
  logic            word_taken = 1'b0;
  int              idle_pct = 0;
  int              accept_cnt = 0;
  int              mismatch_cnt = 0;
  int              cycle_cnt = 0;

  oriented_box_overlap_test_2d_unit #(
    .COORD_WIDTH(CW),
    .TRIG_WIDTH (TW)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_a_center_x(in_a_center_x),
    .in_a_center_y(in_a_center_y),
    .in_a_half_w  (in_a_half_w),
    .in_a_half_h  (in_a_half_h),
    .in_a_cos     (in_a_cos),
    .in_a_sin     (in_a_sin),
    .in_b_center_x(in_b_center_x),
    .in_b_center_y(in_b_center_y),
    .in_b_half_w  (in_b_half_w),
    .in_b_half_h  (in_b_half_h),
    .in_b_cos     (in_b_cos),
    .in_b_sin     (in_b_sin),
    .out_valid    (out_valid),
    .out_overlap  (out_overlap)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // 64-bit wrapping magnitude
  function automatic longint mag64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // axes of reference box r tested against box o, offset d taken in r's frame
  function automatic bit axis_separates(longint dx, longint dy,
                                        longint oc, longint os, longint ohw, longint ohh,
                                        longint rc, longint rs, longint rhw, longint rhh);
    longint proj[2], ext[2], half[2];
    longint c, h;
    proj[0] = rc * dx + rs * dy;
    proj[1] = -(rs * dx) + rc * dy;
    ext[0]  = mag64(rc * oc + rs * os) * ohw + mag64(rs * oc - rc * os) * ohh;
    ext[1]  = mag64(rc * os - rs * oc) * ohw + mag64(rs * os + rc * oc) * ohh;
    half[0] = rhw;
    half[1] = rhh;
    for (int k = 0; k < 2; k++) begin
      c = proj[k] << TRIG_FRAC;
      h = half[k] << (2 * TRIG_FRAC);
      // strict compares: touching boxes still overlap
      if ((c + ext[k] < -h) || (h < c - ext[k])) return 1'b1;
    end
    return 1'b0;
  endfunction

  // overlap flag of one box pair: axes of b first, then axes of a
  function automatic bit boxes_overlap(box_pair_t p);
    longint ax  = longint'(p.a_cx);
    longint ay  = longint'(p.a_cy);
    longint ahw = longint'(p.a_hw);
    longint ahh = longint'(p.a_hh);
    longint ac  = longint'(p.a_cos);
    longint asn = longint'(p.a_sin);
    longint bx  = longint'(p.b_cx);
    longint by  = longint'(p.b_cy);
    longint bhw = longint'(p.b_hw);
    longint bhh = longint'(p.b_hh);
    longint bc  = longint'(p.b_cos);
    longint bsn = longint'(p.b_sin);
    if (axis_separates(ax - bx, ay - by, ac, asn, ahw, ahh, bc, bsn, bhw, bhh)) return 1'b0;
    if (axis_separates(bx - ax, by - ay, bc, bsn, bhw, bhh, ac, asn, ahw, ahh)) return 1'b0;
    return 1'b1;
  endfunction

  // one of the four exact right-angle frames
  function automatic void pick_right_angle(output logic signed [TW-1:0] c,
                                           output logic signed [TW-1:0] s);
    case ($urandom_range(0, 3))
      0: begin c = TW'(UNIT_POS); s = '0;             end
      1: begin c = TW'(UNIT_NEG); s = '0;             end
      2: begin c = '0;            s = TW'(UNIT_POS);  end
      default: begin c = '0;      s = TW'(UNIT_NEG);  end
    endcase
  endfunction

  // random pair: mostly nearby boxes around the decision edge, some raw noise
  function automatic box_pair_t rand_box_pair();
    box_pair_t p;
    int kind, reach, dx, dy, ex, ey;
    real ang;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      // raw fields, every bit free
      p.a_cx = CW'($urandom); p.a_cy = CW'($urandom);
      p.a_hw = (CW-1)'($urandom); p.a_hh = (CW-1)'($urandom);
      p.a_cos = TW'($urandom); p.a_sin = TW'($urandom);
      p.b_cx = CW'($urandom); p.b_cy = CW'($urandom);
      p.b_hw = (CW-1)'($urandom); p.b_hh = (CW-1)'($urandom);
      p.b_cos = TW'($urandom); p.b_sin = TW'($urandom);
      return p;
    end
    p.a_cx = CW'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    p.a_cy = CW'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
    p.a_hw = (CW-1)'($urandom_range(0, 4096));
    p.a_hh = (CW-1)'($urandom_range(0, 4096));
    p.b_hw = (CW-1)'($urandom_range(0, 4096));
    p.b_hh = (CW-1)'($urandom_range(0, 4096));
    if (kind < 45) begin
      // right-angle frames, offset at touching distance plus or minus one lsb
      pick_right_angle(p.a_cos, p.a_sin);
      pick_right_angle(p.b_cos, p.b_sin);
      ex = int'((p.a_cos != '0) ? p.a_hw : p.a_hh) + int'((p.b_cos != '0) ? p.b_hw : p.b_hh);
      ey = int'((p.a_cos != '0) ? p.a_hh : p.a_hw) + int'((p.b_cos != '0) ? p.b_hh : p.b_hw);
      dx = (($urandom_range(0, 1) != 0) ? ex : -ex) + int'($urandom_range(0, 2)) - 1;
      dy = int'($urandom_range(0, 2 * ey)) - ey;
      if ($urandom_range(0, 1) != 0) begin
        p.b_cx = CW'(int'(p.a_cx) + dx);
        p.b_cy = CW'(int'(p.a_cy) + dy);
      end else begin
        p.b_cx = CW'(int'(p.a_cx) + dy);
        p.b_cy = CW'(int'(p.a_cy) + dx);
      end
      return p;
    end
    // unit frames at arbitrary angles, now and then non-unit trig pairs
    if (kind < 90) begin
      ang     = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
      p.a_cos = TW'($rtoi(32767.0 * $cos(ang)));
      p.a_sin = TW'($rtoi(32767.0 * $sin(ang)));
      ang     = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
      p.b_cos = TW'($rtoi(32767.0 * $cos(ang)));
      p.b_sin = TW'($rtoi(32767.0 * $sin(ang)));
    end else begin
      p.a_cos = TW'($urandom); p.a_sin = TW'($urandom);
      p.b_cos = TW'($urandom); p.b_sin = TW'($urandom);
    end
    reach  = int'(p.a_hw) + int'(p.a_hh) + int'(p.b_hw) + int'(p.b_hh) + 8;
    p.b_cx = CW'(int'(p.a_cx) + int'($urandom_range(0, 2 * reach)) - reach);
    p.b_cy = CW'(int'(p.a_cy) + int'($urandom_range(0, 2 * reach)) - reach);
    return p;
  endfunction

  task automatic queue_pair(int acx, int acy, int ahw, int ahh, int acs, int asn,
                            int bcx, int bcy, int bhw, int bhh, int bcs, int bsn);
    box_pair_t p;
    p.a_cx = CW'(acx); p.a_cy = CW'(acy);
    p.a_hw = (CW-1)'(ahw); p.a_hh = (CW-1)'(ahh);
    p.a_cos = TW'(acs); p.a_sin = TW'(asn);
    p.b_cx = CW'(bcx); p.b_cy = CW'(bcy);
    p.b_hw = (CW-1)'(bhw); p.b_hh = (CW-1)'(bhh);
    p.b_cos = TW'(bcs); p.b_sin = TW'(bsn);
    pair_backlog_q.push_back(p);
  endtask

  // wait until every queued word is accepted and every result has come back
  task automatic drain_words();
    while (pair_backlog_q.size() != 0 || start || overlap_expect_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  // driver: hold a word until taken, then offer the next one or idle
  always @(negedge clk) begin
    if (rst_n && (!start || word_taken)) begin
      if (pair_backlog_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        pair_on_port  <= pair_backlog_q[0];
        in_a_center_x <= pair_backlog_q[0].a_cx;
        in_a_center_y <= pair_backlog_q[0].a_cy;
        in_a_half_w   <= pair_backlog_q[0].a_hw;
        in_a_half_h   <= pair_backlog_q[0].a_hh;
        in_a_cos      <= pair_backlog_q[0].a_cos;
        in_a_sin      <= pair_backlog_q[0].a_sin;
        in_b_center_x <= pair_backlog_q[0].b_cx;
        in_b_center_y <= pair_backlog_q[0].b_cy;
        in_b_half_w   <= pair_backlog_q[0].b_hw;
        in_b_half_h   <= pair_backlog_q[0].b_hh;
        in_b_cos      <= pair_backlog_q[0].b_cos;
        in_b_sin      <= pair_backlog_q[0].b_sin;
        void'(pair_backlog_q.pop_front());
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check result words in order, predict each accepted word
  always @(posedge clk) begin
    word_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (overlap_expect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("unexpected result word: overlap=%b", out_overlap);
        end else begin
          head = overlap_expect_q.pop_front();
          if (out_overlap !== head.overlap) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX)
              $display("word %0d: overlap expected %b, got %b",
                       head.idx, head.overlap, out_overlap);
          end
        end
      end
      if (start && !busy) begin
        overlap_expect_q.push_back('{idx: accept_cnt, overlap: boxes_overlap(pair_on_port)});
        accept_cnt++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    int phase_idle[3];
    int phase_items[3];
    phase_idle  = '{0, 86, 29};
    phase_items = '{300, 250, 300};
    idle_pct    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // identical aligned boxes, then clearly apart
    queue_pair(0, 0, 256, 256, UNIT_POS, 0, 0, 0, 256, 256, UNIT_POS, 0);
    queue_pair(0, 0, 256, 256, UNIT_POS, 0, 4096, 0, 256, 256, UNIT_POS, 0);
    // exact touch along x and one lsb apart, flipped exact frame
    queue_pair(0, 0, 256, 256, UNIT_NEG, 0, 512, 0, 256, 256, UNIT_NEG, 0);
    queue_pair(0, 0, 256, 256, UNIT_NEG, 0, 513, 0, 256, 256, UNIT_NEG, 0);
    // same along y with quarter-turn frames
    queue_pair(0, 0, 256, 128, 0, UNIT_NEG, 0, 512, 256, 128, 0, UNIT_NEG);
    queue_pair(0, 0, 256, 128, 0, UNIT_NEG, 0, -513, 256, 128, 0, UNIT_NEG);
    // zero-size boxes, same point and one lsb apart
    queue_pair(100, -100, 0, 0, UNIT_POS, 0, 100, -100, 0, 0, UNIT_POS, 0);
    queue_pair(100, -100, 0, 0, UNIT_POS, 0, 101, -100, 0, 0, UNIT_POS, 0);
    // extreme centers, half sizes and trig values
    queue_pair(CRD_MAX, CRD_MAX, HALF_MAX, HALF_MAX, UNIT_POS, UNIT_POS,
               CRD_MIN, CRD_MIN, HALF_MAX, HALF_MAX, UNIT_NEG, UNIT_NEG);
    queue_pair(CRD_MIN, CRD_MAX, 0, HALF_MAX, UNIT_NEG, UNIT_POS,
               CRD_MAX, CRD_MIN, HALF_MAX, 0, UNIT_POS, UNIT_NEG);
    queue_pair(CRD_MIN, CRD_MIN, 0, 0, UNIT_POS, UNIT_POS,
               CRD_MAX, CRD_MAX, 0, 0, UNIT_NEG, UNIT_POS);
    queue_pair(0, 0, HALF_MAX, HALF_MAX, UNIT_NEG, UNIT_NEG,
               0, 0, HALF_MAX, HALF_MAX, UNIT_POS, UNIT_NEG);
    queue_pair(CRD_MAX, 0, HALF_MAX, 0, UNIT_POS, 0, CRD_MIN, 0, HALF_MAX, 0, UNIT_NEG, 0);
    // collapsed frames: zero trig pair on a, on b, on both
    queue_pair(0, 0, 500, 500, 0, 0, 300, 300, 200, 200, UNIT_POS, 0);
    queue_pair(0, 0, 500, 500, UNIT_POS, 0, 3000, 300, 200, 200, 0, 0);
    queue_pair(-5000, 7000, 10, 10, 0, 0, 5000, -7000, 10, 10, 0, 0);
    // 45 degree box against an aligned one near its corner, then against a box turned the other way
    queue_pair(0, 0, 1000, 100, 23170, 23170, 800, 800, 100, 100, UNIT_POS, 0);
    queue_pair(0, 0, 1000, 100, 23170, 23170, 900, -700, 100, 100, UNIT_POS, 0);
    queue_pair(0, 0, 1000, 1000, 23170, -23170, 1500, 0, 100, 100, 23170, 23170);
    // small rotated box inside a large one
    queue_pair(0, 0, 100000, 100000, UNIT_POS, 0, 2000, -3000, 50, 20, 12540, 30273);
    // non-unit trig pairs, left unnormalized
    queue_pair(1000, 1000, 4000, 300, UNIT_NEG, UNIT_NEG, 1200, 900, 50, 50, 1, -1);
    queue_pair(0, 0, 300, 300, 16384, 0, 500, 0, 300, 300, 16384, 0);

    // random phases, each drained before the idling changes
    for (int ph = 0; ph < 3; ph++) begin
      if (ph != 0) idle_pct = phase_idle[ph];
      repeat (phase_items[ph]) pair_backlog_q.push_back(rand_box_pair());
      drain_words();
    end

    repeat (SETTLE_CYC) @(posedge clk);
    #1;
    if (mismatch_cnt == 0 && overlap_expect_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
